// File: sv/afmu_pkg.sv
`default_nettype none

package afmu_pkg;

    // default sizing
    localparam int AFMU_MAX_SYMBOLS = 256;
    localparam int AFMU_COUNT_BITS  = 25;

    // fixed field widths of the words on the ports
    localparam int SYM_W      = 8;
    localparam int ALPHA_W    = 9;
    localparam int STEP_W     = 8;
    localparam int LIMIT_W    = 5;
    localparam int SEED_W     = 8;
    localparam int CNT_OUT_W  = 25;
    localparam int CFG_DATA_W = 9;
    localparam int CFG_IDX_W  = 2;

    // register reset values
    localparam int RST_ALPHABET  = 256;
    localparam int RST_STEP      = 8;
    localparam int RST_LIMIT     = 13;
    localparam int RST_KEEP_ZERO = 0;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALPHABET  = 2'd0,
        CFG_STEP      = 2'd1,
        CFG_LIMIT     = 2'd2,
        CFG_KEEP_ZERO = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        MODE_UPDATE = 1'b0,
        MODE_SEED   = 1'b1
    } t_mode;

    typedef enum logic [2:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_UPDATE,
        BK_SEED_SUM,
        BK_RESCALE
    } t_back_state;

    typedef struct packed {
        logic              mode;
        logic [SYM_W-1:0]  symbol;
        logic              use_step;
        logic [SEED_W-1:0] seed_count;
    } t_in_item;

    typedef struct packed {
        logic [CNT_OUT_W-1:0] symbol_count;
        logic [CNT_OUT_W-1:0] total_count;
        logic                 rescaled;
        logic                 bad_symbol;
    } t_out_item;

    // classified command handed from front to back
    typedef struct packed {
        logic              mode;
        logic [SYM_W-1:0]  symbol;
        logic [STEP_W-1:0] add;
        logic [SEED_W-1:0] seed;
        logic              bad;
    } t_cmd;

    typedef struct packed {
        logic clearing;
    } t_back_status;

endpackage

`default_nettype wire

// File: sv/adaptive_frequency_model_update.sv
`default_nettype none

// Adaptive frequency table for an arithmetic coder. After reset the block
// sets every count to one in a clearing pass, with busy high. A word is
// taken when start is high and busy is low; a small queue lets a few words
// wait while the table logic works. Each word gives exactly one result,
// shown for one cycle with o_valid high; the receiver cannot stall it. A bad
// symbol is answered from the idle state, an update reads its count and
// writes it back, a seed then adds the new count to the total, and an update
// that reaches the limit runs a halving sweep over the in-use entries, one
// entry per cycle. The user must make configuration writes through i_cfg_we
// only while no words are outstanding; the block itself does not enforce this.
module adaptive_frequency_model_update
    import afmu_pkg::*;
#(
    parameter int MAX_SYMBOLS = AFMU_MAX_SYMBOLS,
    parameter int COUNT_BITS  = AFMU_COUNT_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    input  wire t_in_item              i_item,
    output logic                       busy,
    output logic                       o_valid,
    output t_out_item                  o_result,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW1 = $clog2(MAX_SYMBOLS + 1);
    localparam int CW  = (AW1 > ALPHA_W) ? AW1 : ALPHA_W;

    logic [ALPHA_W-1:0] r_alphabet;
    logic [STEP_W-1:0]  r_step;
    logic [LIMIT_W-1:0] r_limit;
    logic               r_keep_zero;

    logic [AW1-1:0] alpha;
    logic           q_push;
    logic           q_pop;
    logic           q_valid;
    logic           q_full;
    t_cmd           push_cmd;
    t_cmd           head_cmd;
    t_back_status   status;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alphabet  <= ALPHA_W'(RST_ALPHABET);
            r_step      <= STEP_W'(RST_STEP);
            r_limit     <= LIMIT_W'(RST_LIMIT);
            r_keep_zero <= 1'(RST_KEEP_ZERO);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ALPHABET:  r_alphabet  <= i_cfg_data[ALPHA_W-1:0];
                CFG_STEP:      r_step      <= i_cfg_data[STEP_W-1:0];
                CFG_LIMIT:     r_limit     <= i_cfg_data[LIMIT_W-1:0];
                CFG_KEEP_ZERO: r_keep_zero <= i_cfg_data[0];
                default:       r_keep_zero <= r_keep_zero;
            endcase
        end
    end

    // alphabet in use, capped at the table depth
    assign alpha = (CW'(r_alphabet) > CW'(MAX_SYMBOLS)) ? AW1'(MAX_SYMBOLS)
                                                        : AW1'(r_alphabet);

    afmu_front #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_front (
        .i_start      (start),
        .i_item       (i_item),
        .i_alpha      (alpha),
        .i_step       (r_step),
        .i_queue_full (q_full),
        .i_status     (status),
        .o_busy       (busy),
        .o_push       (q_push),
        .o_cmd        (push_cmd)
    );

    afmu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .i_pop   (q_pop),
        .o_head  (head_cmd),
        .o_valid (q_valid),
        .o_full  (q_full)
    );

    afmu_back #(
        .MAX_SYMBOLS (MAX_SYMBOLS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (head_cmd),
        .o_pop       (q_pop),
        .i_alpha     (alpha),
        .i_limit     (r_limit),
        .i_keep_zero (r_keep_zero),
        .o_status    (status),
        .o_valid     (o_valid),
        .o_result    (o_result)
    );

`ifndef SYNTH
    // no result may appear while the table is being cleared
    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.clearing |-> !o_valid)
        else $error("result during clearing pass");

    // the queue never takes a word it has no room for
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("queue overrun");

    // the clearing pass holds the input off right after reset
    a_busy_after_reset: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> busy)
        else $error("not busy after reset");

    // a bad symbol result carries no count and no rescale
    a_bad_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.bad_symbol) |->
            (o_result.symbol_count == '0 && !o_result.rescaled))
        else $error("bad symbol result malformed");
`endif

endmodule

`default_nettype wire

// File: sv/afmu_queue.sv
`default_nettype none

module afmu_queue
    import afmu_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    input  wire logic i_pop,
    output t_cmd      o_head,
    output logic      o_valid,
    output logic      o_full
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    t_cmd          r_slot [QUEUE_DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [NW-1:0] r_num;

    logic do_push;
    logic do_pop;

    assign o_valid = (r_num != '0);
    assign o_full  = (r_num == NW'(QUEUE_DEPTH));
    assign o_head  = r_slot[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_num <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_num <= r_num + NW'(1);
            end else if (do_pop && !do_push) begin
                r_num <= r_num - NW'(1);
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wp] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

// File: sv/afmu_front.sv
`default_nettype none

module afmu_front
    import afmu_pkg::*;
#(
    parameter int MAX_SYMBOLS = AFMU_MAX_SYMBOLS
) (
    input  wire logic                                i_start,
    input  wire t_in_item                            i_item,
    input  wire logic [$clog2(MAX_SYMBOLS + 1)-1:0] i_alpha,
    input  wire logic [STEP_W-1:0]                   i_step,
    input  wire logic                                i_queue_full,
    input  wire t_back_status                        i_status,
    output logic                                     o_busy,
    output logic                                     o_push,
    output t_cmd                                     o_cmd
);

    localparam int AW1 = $clog2(MAX_SYMBOLS + 1);
    localparam int SW  = (AW1 > SYM_W) ? AW1 : SYM_W;

    // hold off while the table clears or the queue has no room
    assign o_busy = i_queue_full || i_status.clearing;
    assign o_push = i_start && !o_busy;

    // classify the word: bad symbol check and increment choice
    always_comb begin
        o_cmd.mode   = i_item.mode;
        o_cmd.symbol = i_item.symbol;
        o_cmd.add    = i_item.use_step ? i_step : STEP_W'(1);
        o_cmd.seed   = i_item.seed_count;
        o_cmd.bad    = (SW'(i_item.symbol) >= SW'(i_alpha));
    end

endmodule

`default_nettype wire

// File: sv/afmu_back.sv
`default_nettype none

module afmu_back
    import afmu_pkg::*;
#(
    parameter int MAX_SYMBOLS = AFMU_MAX_SYMBOLS,
    parameter int COUNT_BITS  = AFMU_COUNT_BITS
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cmd_valid,
    input  wire t_cmd                                i_cmd,
    output logic                                     o_pop,
    input  wire logic [$clog2(MAX_SYMBOLS + 1)-1:0] i_alpha,
    input  wire logic [LIMIT_W-1:0]                  i_limit,
    input  wire logic                                i_keep_zero,
    output t_back_status                             o_status,
    output logic                                     o_valid,
    output t_out_item                                o_result
);

    localparam int AW1 = $clog2(MAX_SYMBOLS + 1);
    localparam int AW  = $clog2(MAX_SYMBOLS);
    localparam int CB  = COUNT_BITS;
    localparam longint CNT_MAX     = (64'd1 << COUNT_BITS) - 64'd1;
    localparam longint RST_ALPHA   = (RST_ALPHABET > MAX_SYMBOLS) ? MAX_SYMBOLS : RST_ALPHABET;
    localparam longint RST_TOTAL   = (RST_ALPHA > CNT_MAX) ? CNT_MAX : RST_ALPHA;

    t_back_state r_state;
    t_back_state n_state;

    // count table
    logic [CB-1:0] r_table [MAX_SYMBOLS];
    logic [CB-1:0] r_rdata;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [CB-1:0] mem_wd;
    logic [AW-1:0] mem_ra;

    // datapath registers
    logic [AW1-1:0] r_idx,   n_idx;
    logic [AW1-1:0] r_widx,  n_widx;
    logic           r_rv,    n_rv;
    logic [CB-1:0]  r_total, n_total;
    logic [CB-1:0]  r_sum,   n_sum;
    logic [CB-1:0]  r_cnt,   n_cnt;
    t_cmd           r_cmd,   n_cmd;
    logic           r_valid, n_valid;
    t_out_item      r_result, n_result;

    // arithmetic helpers
    logic [CB:0]   cnt_add;
    logic [CB-1:0] cnt_new;
    logic [CB:0]   tot_add;
    logic [CB-1:0] tot_new;
    logic [CB-1:0] seed_base;
    logic [CB:0]   seed_add;
    logic [CB-1:0] seed_tot;
    logic [CB-1:0] thr;
    logic          resc_hit;
    logic          skip_zero;
    logic [CB-1:0] half_new;
    logic [CB:0]   sum_add;
    logic [CB-1:0] sum_new;
    logic [CB-1:0] cnt_final;
    logic [AW-1:0] cmd_addr;
    logic          read_more;
    logic          last_wr;

    assign o_status.clearing = (r_state == BK_CLEAR);
    assign o_valid  = r_valid;
    assign o_result = r_result;
    assign cmd_addr = AW'(r_cmd.symbol);

    // update arithmetic: count and total each take the increment, saturating
    always_comb begin
        cnt_add  = {1'b0, r_rdata} + (CB + 1)'(r_cmd.add);
        cnt_new  = cnt_add[CB] ? '1 : cnt_add[CB-1:0];
        tot_add  = {1'b0, r_total} + (CB + 1)'(r_cmd.add);
        tot_new  = tot_add[CB] ? '1 : tot_add[CB-1:0];
        thr      = CB'(1) << i_limit;
        resc_hit = (int'(i_limit) < COUNT_BITS) && (tot_new >= thr);
    end

    // seed arithmetic: remove old count, then add the new one next cycle
    always_comb begin
        seed_base = (r_total >= r_rdata) ? (r_total - r_rdata) : '0;
        seed_add  = {1'b0, r_total} + {1'b0, r_cnt};
        seed_tot  = seed_add[CB] ? '1 : seed_add[CB-1:0];
    end

    // rescale arithmetic on the entry returning from the table
    always_comb begin
        skip_zero = i_keep_zero && (r_rdata == '0);
        half_new  = skip_zero ? '0 : ((r_rdata >> 1) + CB'(1));
        sum_add   = {1'b0, r_sum} + {1'b0, half_new};
        sum_new   = sum_add[CB] ? '1 : sum_add[CB-1:0];
        cnt_final = (r_widx[AW-1:0] == cmd_addr) ? half_new : r_cnt;
        read_more = (r_idx < i_alpha);
        last_wr   = r_rv && (r_widx == i_alpha - AW1'(1));
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_CLEAR: begin
                if (r_idx == AW1'(MAX_SYMBOLS - 1)) begin
                    n_state = BK_IDLE;
                end
            end
            BK_IDLE: begin
                if (i_cmd_valid && !i_cmd.bad) begin
                    n_state = BK_UPDATE;
                end
            end
            BK_UPDATE: begin
                if (r_cmd.mode == MODE_SEED) begin
                    n_state = BK_SEED_SUM;
                end else if (resc_hit) begin
                    n_state = BK_RESCALE;
                end else begin
                    n_state = BK_IDLE;
                end
            end
            BK_SEED_SUM: begin
                n_state = BK_IDLE;
            end
            BK_RESCALE: begin
                if (last_wr) begin
                    n_state = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_CLEAR;
            end
        endcase
    end

    // table control and datapath next values
    always_comb begin
        o_pop    = 1'b0;
        mem_we   = 1'b0;
        mem_wa   = cmd_addr;
        mem_wd   = '0;
        mem_ra   = AW'(i_cmd.symbol);
        n_idx    = r_idx;
        n_widx   = r_widx;
        n_rv     = 1'b0;
        n_total  = r_total;
        n_sum    = r_sum;
        n_cnt    = r_cnt;
        n_cmd    = r_cmd;
        n_valid  = 1'b0;
        n_result = r_result;
        unique case (r_state)
            BK_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_idx[AW-1:0];
                mem_wd = CB'(1);
                n_idx  = (r_idx == AW1'(MAX_SYMBOLS - 1)) ? '0 : r_idx + AW1'(1);
            end
            BK_IDLE: begin
                if (i_cmd_valid) begin
                    o_pop = 1'b1;
                    n_cmd = i_cmd;
                    if (i_cmd.bad) begin
                        n_valid               = 1'b1;
                        n_result.symbol_count = '0;
                        n_result.total_count  = CNT_OUT_W'(r_total);
                        n_result.rescaled     = 1'b0;
                        n_result.bad_symbol   = 1'b1;
                    end
                end
            end
            BK_UPDATE: begin
                mem_we = 1'b1;
                mem_wa = cmd_addr;
                if (r_cmd.mode == MODE_SEED) begin
                    mem_wd  = CB'(r_cmd.seed);
                    n_cnt   = CB'(r_cmd.seed);
                    n_total = seed_base;
                end else begin
                    mem_wd  = cnt_new;
                    n_cnt   = cnt_new;
                    n_total = tot_new;
                    if (resc_hit) begin
                        n_idx  = '0;
                        n_widx = '0;
                        n_sum  = '0;
                    end else begin
                        n_valid               = 1'b1;
                        n_result.symbol_count = CNT_OUT_W'(cnt_new);
                        n_result.total_count  = CNT_OUT_W'(tot_new);
                        n_result.rescaled     = 1'b0;
                        n_result.bad_symbol   = 1'b0;
                    end
                end
            end
            BK_SEED_SUM: begin
                n_total               = seed_tot;
                n_valid               = 1'b1;
                n_result.symbol_count = CNT_OUT_W'(r_cnt);
                n_result.total_count  = CNT_OUT_W'(seed_tot);
                n_result.rescaled     = 1'b0;
                n_result.bad_symbol   = 1'b0;
            end
            BK_RESCALE: begin
                // read side runs one entry ahead of the write side
                mem_ra = r_idx[AW-1:0];
                if (read_more) begin
                    n_idx = r_idx + AW1'(1);
                    n_rv  = 1'b1;
                end
                if (r_rv) begin
                    mem_we = !skip_zero;
                    mem_wa = r_widx[AW-1:0];
                    mem_wd = half_new;
                    n_sum  = skip_zero ? r_sum : sum_new;
                    n_cnt  = cnt_final;
                    n_widx = r_widx + AW1'(1);
                end
                if (last_wr) begin
                    n_total               = skip_zero ? r_sum : sum_new;
                    n_valid               = 1'b1;
                    n_result.symbol_count = CNT_OUT_W'(cnt_final);
                    n_result.total_count  = CNT_OUT_W'(skip_zero ? r_sum : sum_new);
                    n_result.rescaled     = 1'b1;
                    n_result.bad_symbol   = 1'b0;
                end
            end
            default: begin
                n_idx = '0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_CLEAR;
            r_idx   <= '0;
            r_widx  <= '0;
            r_rv    <= 1'b0;
            r_total <= CB'(RST_TOTAL);
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_widx  <= n_widx;
            r_rv    <= n_rv;
            r_total <= n_total;
            r_valid <= n_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_sum    <= n_sum;
        r_cnt    <= n_cnt;
        r_cmd    <= n_cmd;
        r_result <= n_result;
    end

    // table write port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_table[mem_wa] <= mem_wd;
        end
    end

    // table read port, registered
    always_ff @(posedge i_clk) begin
        r_rdata <= r_table[mem_ra];
    end

endmodule

`default_nettype wire

// File: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import afmu_pkg::*;

    localparam int          MAX_SYM     = AFMU_MAX_SYMBOLS;
    localparam int          CNT_W       = AFMU_COUNT_BITS;
    localparam longint      CNT_MAX     = (64'd1 << CNT_W) - 1;
    localparam int unsigned CYCLE_LIMIT = 2_000_000;
    localparam int          MAX_REPORTS = 30;
    // long enough to cover a full rescale sweep of the largest table
    localparam int          SETTLE_CYC  = MAX_SYM + 40;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  start      = 1'b0;
    t_in_item              i_item     = '0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = CFG_ALPHABET;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  busy;
    logic                  o_valid;
    t_out_item             o_result;

    // predictor state: count table, running total and register copies
    longint unsigned       freq_table [MAX_SYM];
    longint unsigned       freq_total;
    logic [ALPHA_W-1:0]    cfg_alpha;
    logic [STEP_W-1:0]     cfg_step;
    logic [LIMIT_W-1:0]    cfg_limit;
    logic                  cfg_keep_zero;

    t_out_item             pending_results [$];

    int unsigned           cycle_cnt     = 0;
    int unsigned           err_cnt       = 0;
    int unsigned           words_sent    = 0;
    int unsigned           results_seen  = 0;
    int unsigned           rescale_cnt   = 0;
    int unsigned           bad_cnt       = 0;
    int unsigned           settings_used = 0;
    int unsigned           burst_left    = 0;

    adaptive_frequency_model_update DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_item     (i_item),
        .busy       (busy),
        .o_valid    (o_valid),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // run-away guard
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("adaptive_frequency_model_update test failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------
    function automatic longint unsigned sat_count(longint unsigned v);
        return (v > CNT_MAX) ? CNT_MAX : v;
    endfunction

    // symbols in use: the register value, capped at the table size
    function automatic int unsigned symbols_in_use();
        return (cfg_alpha > MAX_SYM) ? MAX_SYM : int'(cfg_alpha);
    endfunction

    function automatic void reset_freq_model();
        cfg_alpha     = ALPHA_W'(RST_ALPHABET);
        cfg_step      = STEP_W'(RST_STEP);
        cfg_limit     = LIMIT_W'(RST_LIMIT);
        cfg_keep_zero = 1'(RST_KEEP_ZERO);
        foreach (freq_table[i])
            freq_table[i] = 1;
        freq_total = sat_count(symbols_in_use());
    endfunction

    // apply one word to the table and return the result it must produce
    function automatic t_out_item apply_freq_word(t_in_item w);
        t_out_item       r;
        int unsigned     span;
        int unsigned     s;
        longint unsigned add;
        longint unsigned old_c;
        longint unsigned base;
        longint unsigned sum;
        longint unsigned c;
        r    = '0;
        span = symbols_in_use();
        s    = w.symbol;
        if (s >= span) begin
            // ignored: table untouched
            r.total_count = freq_total[CNT_OUT_W-1:0];
            r.bad_symbol  = 1'b1;
            return r;
        end
        if (w.mode == MODE_SEED) begin
            old_c         = freq_table[s];
            base          = (freq_total >= old_c) ? freq_total - old_c : 0;
            freq_table[s] = sat_count(w.seed_count);
            freq_total    = sat_count(base + freq_table[s]);
        end else begin
            add           = w.use_step ? longint'(cfg_step) : 1;
            freq_table[s] = sat_count(freq_table[s] + add);
            freq_total    = sat_count(freq_total + add);
            if (cfg_limit < CNT_W && freq_total >= (64'd1 << cfg_limit)) begin
                // halving sweep over the in-use part of the table
                sum = 0;
                for (int i = 0; i < span; i++) begin
                    c = freq_table[i];
                    if (!(cfg_keep_zero && c == 0)) begin
                        c             = sat_count((c >> 1) + 1);
                        freq_table[i] = c;
                        sum           = sat_count(sum + c);
                    end
                end
                freq_total = sum;
                r.rescaled = 1'b1;
            end
        end
        r.symbol_count = freq_table[s][CNT_OUT_W-1:0];
        r.total_count  = freq_total[CNT_OUT_W-1:0];
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Result checker
    // ---------------------------------------------------------------
    task automatic note_mismatch(input string fld, input int unsigned want,
                                 input int unsigned got);
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
            $display("%0t: result %0d %s expected %0d actual %0d",
                     $time, results_seen, fld, want, got);
    endtask

    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                err_cnt++;
                if (err_cnt <= MAX_REPORTS)
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, o_result);
            end else begin
                want = pending_results.pop_front();
                results_seen++;
                if (o_result.symbol_count !== want.symbol_count)
                    note_mismatch("symbol_count", want.symbol_count,
                                  o_result.symbol_count);
                if (o_result.total_count !== want.total_count)
                    note_mismatch("total_count", want.total_count,
                                  o_result.total_count);
                if (o_result.rescaled !== want.rescaled)
                    note_mismatch("rescaled", want.rescaled, o_result.rescaled);
                if (o_result.bad_symbol !== want.bad_symbol)
                    note_mismatch("bad_symbol", want.bad_symbol, o_result.bad_symbol);
                if (want.rescaled)
                    rescale_cnt++;
                if (want.bad_symbol)
                    bad_cnt++;
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    // sender gap: mostly none or short, a few long, with gap-free bursts
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(49, 0) == 0) begin
            burst_left = $urandom_range(60, 20);
            return 0;
        end
        r = $urandom_range(99, 0);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(3, 1);
        else
            return $urandom_range(40, 4);
    endfunction

    function automatic t_in_item make_word(t_mode md, int unsigned sym, bit stp,
                                           int unsigned seed);
        t_in_item w;
        w.mode       = md;
        w.symbol     = SYM_W'(sym);
        w.use_step   = stp;
        w.seed_count = SEED_W'(seed);
        return w;
    endfunction

    function automatic t_in_item rand_word(int unsigned seed_pct);
        t_in_item    w;
        int unsigned span;
        span         = symbols_in_use();
        w.mode       = ($urandom_range(99, 0) < seed_pct) ? MODE_SEED : MODE_UPDATE;
        w.use_step   = 1'($urandom_range(1, 0));
        w.seed_count = ($urandom_range(4, 0) == 0) ? '0 : SEED_W'($urandom_range(255, 0));
        if (span < MAX_SYM && $urandom_range(99, 0) < 6)
            w.symbol = SYM_W'($urandom_range(255, span));
        else
            w.symbol = SYM_W'($urandom_range(span - 1, 0));
        return w;
    endfunction

    // send one word; start stays high for a back-to-back follower
    task automatic send_word(input t_in_item w, input int unsigned gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= w;
        do @(posedge i_clk); while (busy);
        pending_results.push_back(apply_freq_word(w));
        words_sent++;
    endtask

    // stop sending and let every outstanding result come back
    task automatic wait_table_idle();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input int unsigned val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_DATA_W'(val);
        @(posedge i_clk);
        case (idx)
            CFG_ALPHABET:  cfg_alpha     = val[ALPHA_W-1:0];
            CFG_STEP:      cfg_step      = val[STEP_W-1:0];
            CFG_LIMIT:     cfg_limit     = val[LIMIT_W-1:0];
            CFG_KEEP_ZERO: cfg_keep_zero = val[0];
            default: ;
        endcase
    endtask

    // rewrite all registers after waiting for the block to go idle
    task automatic apply_config(input int unsigned alpha, input int unsigned stp,
                                input int unsigned lim, input int unsigned kz);
        wait_table_idle();
        write_reg(CFG_ALPHABET, alpha);
        write_reg(CFG_STEP, stp);
        write_reg(CFG_LIMIT, lim);
        write_reg(CFG_KEEP_ZERO, kz);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic run_phase(input int unsigned alpha, input int unsigned stp,
                             input int unsigned lim, input int unsigned kz,
                             input int unsigned n, input int unsigned seed_pct);
        apply_config(alpha, stp, lim, kz);
        for (int i = 0; i < n; i++) begin
            // now and then hold off until the table has caught up
            if ($urandom_range(199, 0) == 0)
                wait_table_idle();
            send_word(rand_word(seed_pct), pick_gap());
        end
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    // reset register values, field extremes and bit patterns
    task automatic test_reset_defaults();
        send_word(make_word(MODE_UPDATE, 0, 1'b0, 0), pick_gap());
        send_word(make_word(MODE_UPDATE, 255, 1'b1, 255), pick_gap());
        send_word(make_word(MODE_SEED, 8'h55, 1'b1, 8'hAA), pick_gap());
        send_word(make_word(MODE_SEED, 8'hAA, 1'b0, 8'h55), pick_gap());
        send_word(make_word(MODE_SEED, 255, 1'b0, 255), pick_gap());
        send_word(make_word(MODE_SEED, 1, 1'b1, 0), pick_gap());
    endtask

    // out-of-alphabet symbols, empty alphabet, alphabet above table size
    task automatic test_bad_symbols();
        apply_config(200, 8, 13, 0);
        send_word(make_word(MODE_UPDATE, 199, 1'b1, 0), pick_gap());
        send_word(make_word(MODE_SEED, 200, 1'b0, 17), pick_gap());
        apply_config(0, 8, 13, 0);
        send_word(make_word(MODE_UPDATE, 0, 1'b0, 0), pick_gap());
        apply_config(511, 8, 13, 0);
        send_word(make_word(MODE_UPDATE, 255, 1'b1, 0), pick_gap());
        send_word(make_word(MODE_UPDATE, 1, 1'b0, 0), pick_gap());
    endtask

    // zero counts survive a rescale only while keep_zero is set
    task automatic test_keep_zero_rescale();
        apply_config(16, 255, 9, 1);
        send_word(make_word(MODE_SEED, 3, 1'b0, 0), pick_gap());
        send_word(make_word(MODE_SEED, 15, 1'b0, 0), pick_gap());
        repeat (3) send_word(make_word(MODE_UPDATE, 5, 1'b1, 0), pick_gap());
        apply_config(16, 1, 2, 0);
        send_word(make_word(MODE_UPDATE, 7, 1'b0, 0), pick_gap());
    endtask

    // shrink the alphabet, rescale the small part, then seed an entry
    // outside it whose count is larger than the recomputed total
    task automatic test_seed_underflow();
        apply_config(256, 8, 13, 0);
        send_word(make_word(MODE_SEED, 200, 1'b0, 255), pick_gap());
        apply_config(100, 8, 8, 0);
        repeat (6) send_word(make_word(MODE_UPDATE, 0, 1'b0, 0), pick_gap());
        apply_config(256, 8, 24, 0);
        send_word(make_word(MODE_SEED, 200, 1'b1, 7), pick_gap());
    endtask

    task automatic test_random_mix();
        run_phase(256, 8, 10, 0, 350, 20);
        run_phase(256, 255, 14, 1, 350, 30);
        run_phase(1, 1, 2, 0, 150, 15);
        run_phase(2, 255, 24, 1, 150, 25);
        run_phase(300, 3, 9, 0, 250, 20);
        run_phase(256, 1, 11, 1, 200, 20);
        repeat (3)
            run_phase($urandom_range(255, 3), $urandom_range(255, 1),
                      $urandom_range(12, 8), $urandom_range(1, 0), 150, 20);
    endtask

    // limit beyond the count width: no rescale however far the total
    // grows; then large steps against the widest reachable limit
    task automatic test_saturation();
        apply_config(256, 255, 31, 0);
        burst_left = 0;
        repeat (20) send_word(make_word(MODE_UPDATE, 0, 1'b1, 0), 0);
        send_word(make_word(MODE_SEED, 5, 1'b0, 3), pick_gap());
        send_word(make_word(MODE_UPDATE, 9, 1'b0, 0), pick_gap());
        apply_config(256, 255, 24, 0);
        send_word(make_word(MODE_UPDATE, 0, 1'b1, 0), pick_gap());
        send_word(make_word(MODE_SEED, 0, 1'b0, 0), pick_gap());
        send_word(make_word(MODE_UPDATE, 0, 1'b0, 0), pick_gap());
    endtask

    initial begin
        reset_freq_model();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_bad_symbols();
        test_keep_zero_rescale();
        test_seed_underflow();
        test_random_mix();
        test_saturation();

        wait_table_idle();
        repeat (SETTLE_CYC) @(posedge i_clk);

        $display("Sent %0d words over %0d register settings; checked %0d results",
                 words_sent, settings_used, results_seen);
        $display("Seen %0d rescale sweeps and %0d ignored symbols; %0d mismatches",
                 rescale_cnt, bad_cnt, err_cnt);
        if (err_cnt == 0 && pending_results.size() == 0)
            $display("adaptive_frequency_model_update test passed");
        else
            $display("adaptive_frequency_model_update test failed");
        $finish;
    end

endmodule
